/* rtl/petscii_to_ansi_stream_core_macros.svh */
// Assertion macros for the translator RTL.
// Included by p2a_back, which carries the checks; depends on nothing else.
`ifndef PETSCII_TO_ANSI_STREAM_CORE_MACROS_SVH
`define PETSCII_TO_ANSI_STREAM_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define P2A_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("p2a check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define P2A_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("p2a check failed: next-cycle implication");

`endif

/* rtl/p2a_pkg.sv */
// Shared types, byte codes and lookup functions of the PETSCII to ANSI translator.
// Used by the front, queue and back modules; depends on nothing else.
package p2a_pkg;

  // Defaults for the top-level parameters and fixed sizes.
  localparam int CURSOR_BITS_DEFAULT = 8;
  localparam int QUEUE_DEPTH         = 4;
  localparam logic [7:0] COLUMNS_RESET = 8'd40;

  // PETSCII control codes with a fixed meaning.
  localparam logic [7:0] PC_BELL     = 8'h07;
  localparam logic [7:0] PC_CR       = 8'h0D;
  localparam logic [7:0] PC_DOWN     = 8'h11;
  localparam logic [7:0] PC_REV_ON   = 8'h12;
  localparam logic [7:0] PC_HOME     = 8'h13;
  localparam logic [7:0] PC_DELETE   = 8'h14;
  localparam logic [7:0] PC_RIGHT    = 8'h1D;
  localparam logic [7:0] PC_SHIFT_CR = 8'h8D;
  localparam logic [7:0] PC_UP       = 8'h91;
  localparam logic [7:0] PC_REV_OFF  = 8'h92;
  localparam logic [7:0] PC_CLEAR    = 8'h93;
  localparam logic [7:0] PC_LEFT     = 8'h9D;

  // Terminal bytes.
  localparam logic [7:0] T_BEL   = 8'h07;
  localparam logic [7:0] T_BS    = 8'h08;
  localparam logic [7:0] T_LF    = 8'h0A;
  localparam logic [7:0] T_CR    = 8'h0D;
  localparam logic [7:0] T_ESC   = 8'h1B;
  localparam logic [7:0] T_SPACE = 8'h20;
  localparam logic [7:0] T_BRACK = 8'h5B;
  localparam logic [7:0] T_ZERO  = 8'h30;
  localparam logic [7:0] T_ONE   = 8'h31;
  localparam logic [7:0] T_TWO   = 8'h32;
  localparam logic [7:0] T_THREE = 8'h33;
  localparam logic [7:0] T_SEVEN = 8'h37;
  localparam logic [7:0] T_UPA   = 8'h41;
  localparam logic [7:0] T_UPB   = 8'h42;
  localparam logic [7:0] T_UPC   = 8'h43;
  localparam logic [7:0] T_UPD   = 8'h44;
  localparam logic [7:0] T_UPH   = 8'h48;
  localparam logic [7:0] T_UPJ   = 8'h4A;
  localparam logic [7:0] T_LOWM  = 8'h6D;

  // Kind of direct output an item asks for, ahead of any attribute string.
  typedef enum logic [2:0] {
    K_NONE,
    K_PRINT,
    K_CRLF,
    K_HOME,
    K_CLEAR,
    K_CURSOR,
    K_DELETE,
    K_BELL
  } kind_e;

  // One classified item as passed from the front to the back.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;        // printable byte or cursor letter
    logic        colour_set;
    logic [3:0]  colour_idx;
    logic        reverse;
    logic [2:0]  dir_len;     // number of direct bytes
    logic [4:0]  total;       // number of bytes in all
  } job_t;

  typedef struct packed {
    logic       found;
    logic [3:0] idx;
  } colour_hit_t;

  // Map a control byte onto one of the sixteen colours.
  function automatic colour_hit_t colour_lookup(input logic [7:0] b);
    colour_hit_t r;
    r.found = 1'b1;
    unique case (b)
      8'h90:   r.idx = 4'd0;
      8'h05:   r.idx = 4'd1;
      8'h1C:   r.idx = 4'd2;
      8'h9F:   r.idx = 4'd3;
      8'h9C:   r.idx = 4'd4;
      8'h1E:   r.idx = 4'd5;
      8'h1F:   r.idx = 4'd6;
      8'h9E:   r.idx = 4'd7;
      8'h81:   r.idx = 4'd8;
      8'h95:   r.idx = 4'd9;
      8'h96:   r.idx = 4'd10;
      8'h97:   r.idx = 4'd11;
      8'h98:   r.idx = 4'd12;
      8'h99:   r.idx = 4'd13;
      8'h9A:   r.idx = 4'd14;
      8'h9B:   r.idx = 4'd15;
      default: begin
        r.found = 1'b0;
        r.idx   = 4'd0;
      end
    endcase
    return r;
  endfunction

  // Whether the colour is shown bold.
  function automatic logic colour_bold(input logic [3:0] idx);
    logic [15:0] tbl;
    tbl = 16'b1110_1101_1000_0010;
    return tbl[idx];
  endfunction

  // Foreground digit of the colour.
  function automatic logic [7:0] colour_digit(input logic [3:0] idx);
    logic [7:0] d;
    unique case (idx)
      4'd0, 4'd11:         d = 8'h30;
      4'd2, 4'd8, 4'd10:   d = 8'h31;
      4'd5, 4'd13:         d = 8'h32;
      4'd7, 4'd9:          d = 8'h33;
      4'd6, 4'd14:         d = 8'h34;
      4'd4:                d = 8'h35;
      4'd3:                d = 8'h36;
      default:             d = 8'h37;
    endcase
    return d;
  endfunction

  // Length of the attribute string for the given attributes.
  function automatic logic [4:0] attr_len(input logic set, input logic bold, input logic rev);
    logic [4:0] n;
    n = 5'd4;
    if (set) begin
      n = bold ? 5'd13 : 5'd9;
    end
    if (rev) begin
      n = n + 5'd4;
    end
    return n;
  endfunction

  // Byte at position i of the direct part of an item.
  function automatic logic [7:0] direct_byte(input kind_e kind, input logic [7:0] data,
                                             input logic [2:0] i);
    logic [7:0] r;
    r = T_ESC;
    unique case (kind)
      K_PRINT:  r = (i == 3'd0) ? data : ((i == 3'd1) ? T_CR : T_LF);
      K_CRLF:   r = (i == 3'd0) ? T_CR : T_LF;
      K_HOME:   r = (i == 3'd0) ? T_ESC : ((i == 3'd1) ? T_BRACK : T_UPH);
      K_CURSOR: r = (i == 3'd0) ? T_ESC : ((i == 3'd1) ? T_BRACK : data);
      K_DELETE: r = (i == 3'd1) ? T_SPACE : T_BS;
      K_BELL:   r = T_BEL;
      K_CLEAR: begin
        unique case (i)
          3'd0, 3'd4: r = T_ESC;
          3'd1, 3'd5: r = T_BRACK;
          3'd2:       r = T_TWO;
          3'd3:       r = T_UPJ;
          default:    r = T_UPH;
        endcase
      end
      default:  r = T_ESC;
    endcase
    return r;
  endfunction

  // Byte at position j of the attribute string: reset, bold, colour, reverse.
  function automatic logic [7:0] attr_byte(input logic set, input logic bold,
                                           input logic [7:0] digit, input logic rev,
                                           input logic [4:0] j);
    logic [4:0] k;
    logic [7:0] r;
    logic       done;
    r    = T_ESC;
    done = 1'b0;
    k    = j;
    // Reset sequence first.
    if (k < 5'd4) begin
      r    = (k[1:0] == 2'd0) ? T_ESC : ((k[1:0] == 2'd1) ? T_BRACK :
             ((k[1:0] == 2'd2) ? T_ZERO : T_LOWM));
      done = 1'b1;
    end else begin
      k = k - 5'd4;
    end
    // Bold sequence, for the bright colours.
    if (!done && set && bold) begin
      if (k < 5'd4) begin
        r    = (k[1:0] == 2'd0) ? T_ESC : ((k[1:0] == 2'd1) ? T_BRACK :
               ((k[1:0] == 2'd2) ? T_ONE : T_LOWM));
        done = 1'b1;
      end else begin
        k = k - 5'd4;
      end
    end
    // Foreground colour sequence.
    if (!done && set) begin
      if (k < 5'd5) begin
        unique case (k[2:0])
          3'd0:    r = T_ESC;
          3'd1:    r = T_BRACK;
          3'd2:    r = T_THREE;
          3'd3:    r = digit;
          default: r = T_LOWM;
        endcase
        done = 1'b1;
      end else begin
        k = k - 5'd5;
      end
    end
    // Reverse video sequence.
    if (!done && rev) begin
      r = (k[1:0] == 2'd0) ? T_ESC : ((k[1:0] == 2'd1) ? T_BRACK :
          ((k[1:0] == 2'd2) ? T_SEVEN : T_LOWM));
    end
    return r;
  endfunction

endpackage

/* rtl/p2a_front.sv */
// Front of the translator: holds the width register and the terminal state,
// classifies each accepted item and hands a job to the queue. Uses p2a_pkg.
module p2a_front
  import p2a_pkg::*;
#(
  parameter int CURSOR_BITS = CURSOR_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  localparam int CMP_W = (CURSOR_BITS > 8) ? CURSOR_BITS : 8;
  localparam logic [CURSOR_BITS-1:0] CUR_MAX = {CURSOR_BITS{1'b1}};
  localparam logic [CURSOR_BITS-1:0] CUR_ZERO = {CURSOR_BITS{1'b0}};
  localparam logic [CURSOR_BITS-1:0] CUR_ONE = CURSOR_BITS'(1);

  logic [7:0]             columns_q;
  logic [CURSOR_BITS-1:0] col_q, col_d, line_q, line_d;
  logic                   rev_q, rev_d, set_q, set_d;
  logic [3:0]             idx_q, idx_d;

  logic                   is_ctrl;
  logic [CURSOR_BITS-1:0] col_inc, line_inc;
  logic                   wrap;
  logic                   attr;
  kind_e                  kind;
  logic [7:0]             data;
  logic [2:0]             dir_len;
  logic [4:0]             a_len;
  colour_hit_t            hit;

  // Width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RESET;
    end else if (cfg_we_i) begin
      columns_q <= cfg_wdata_i;
    end
  end

  // Saturating increments and the wrap test of printable output.
  assign col_inc  = (col_q == CUR_MAX) ? CUR_MAX : col_q + CUR_ONE;
  assign line_inc = (line_q == CUR_MAX) ? CUR_MAX : line_q + CUR_ONE;
  assign wrap     = CMP_W'(col_inc) >= CMP_W'(columns_q);
  assign is_ctrl  = (in_byte_i[6:5] == 2'b00);
  assign hit      = colour_lookup(in_byte_i);

  // Classification and next terminal state.
  always_comb begin
    col_d   = col_q;
    line_d  = line_q;
    rev_d   = rev_q;
    set_d   = set_q;
    idx_d   = idx_q;
    kind    = K_NONE;
    data    = in_byte_i;
    dir_len = 3'd0;
    if (!is_ctrl) begin
      kind    = K_PRINT;
      dir_len = wrap ? 3'd3 : 3'd1;
      col_d   = wrap ? CUR_ZERO : col_inc;
      line_d  = wrap ? line_inc : line_q;
    end else begin
      unique case (in_byte_i)
        PC_CR: begin
          kind    = K_CRLF;
          dir_len = 3'd2;
          rev_d   = 1'b0;
          col_d   = CUR_ZERO;
          line_d  = line_inc;
        end
        PC_SHIFT_CR: begin
          kind    = K_CRLF;
          dir_len = 3'd2;
          col_d   = CUR_ZERO;
          line_d  = line_inc;
        end
        PC_REV_ON:  rev_d = 1'b1;
        PC_REV_OFF: rev_d = 1'b0;
        PC_HOME: begin
          kind    = K_HOME;
          dir_len = 3'd3;
          col_d   = CUR_ZERO;
          line_d  = CUR_ZERO;
        end
        PC_CLEAR: begin
          kind    = K_CLEAR;
          dir_len = 3'd7;
          col_d   = CUR_ZERO;
          line_d  = CUR_ZERO;
        end
        PC_DOWN: begin
          kind    = K_CURSOR;
          data    = T_UPB;
          dir_len = 3'd3;
          line_d  = line_inc;
        end
        PC_UP: begin
          kind    = K_CURSOR;
          data    = T_UPA;
          dir_len = 3'd3;
          line_d  = (line_q == CUR_ZERO) ? CUR_ZERO : line_q - CUR_ONE;
        end
        PC_RIGHT: begin
          kind    = K_CURSOR;
          data    = T_UPC;
          dir_len = 3'd3;
          col_d   = col_inc;
        end
        PC_LEFT: begin
          kind    = K_CURSOR;
          data    = T_UPD;
          dir_len = 3'd3;
          col_d   = (col_q == CUR_ZERO) ? CUR_ZERO : col_q - CUR_ONE;
        end
        PC_DELETE: begin
          kind    = K_DELETE;
          dir_len = 3'd3;
        end
        PC_BELL: begin
          kind    = K_BELL;
          dir_len = 3'd1;
        end
        default: begin
          if (hit.found) begin
            set_d = 1'b1;
            idx_d = hit.idx;
          end
        end
      endcase
    end
  end

  // The attribute string is rebuilt only when something visible changed.
  assign attr  = is_ctrl && ((set_d != set_q) || (rev_d != rev_q) ||
                 (set_d && (idx_d != idx_q)));
  assign a_len = attr_len(set_d, colour_bold(idx_d), rev_d);

  // Job handed to the queue; items with nothing to say take no slot.
  always_comb begin
    job_o.kind       = kind;
    job_o.data       = data;
    job_o.colour_set = set_d;
    job_o.colour_idx = idx_d;
    job_o.reverse    = rev_d;
    job_o.dir_len    = dir_len;
    job_o.total      = {2'b00, dir_len} + (attr ? a_len : 5'd0);
  end
  assign job_valid_o = accept_i && ((kind != K_NONE) || attr);

  // Terminal state, updated when the item is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= CUR_ZERO;
      line_q <= CUR_ZERO;
      rev_q  <= 1'b0;
      set_q  <= 1'b0;
      idx_q  <= 4'd0;
    end else if (accept_i) begin
      col_q  <= col_d;
      line_q <= line_d;
      rev_q  <= rev_d;
      set_q  <= set_d;
      idx_q  <= idx_d;
    end
  end

endmodule

/* rtl/p2a_queue.sv */
// Short job queue between the front and the back of the translator.
// Register based, first in first out. Uses p2a_pkg.
module p2a_queue
  import p2a_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t head_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  job_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage of queued jobs.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* rtl/p2a_back.sv */
// Back of the translator: expands the queue's head job into terminal bytes
// through an output register, one per cycle unless stalled. Uses p2a_pkg.
`include "petscii_to_ansi_stream_core_macros.svh"
module p2a_back
  import p2a_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic [4:0] pos_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       advance;
  logic       in_direct;
  logic       is_last;
  logic [7:0] next_byte;
  logic [4:0] attr_pos;

  // Room in the output register, either free or being taken now.
  assign advance = job_valid_i && (!out_valid_q || pop_i);

  // Byte at the current position of the head job.
  assign in_direct = pos_q < {2'b00, job_i.dir_len};
  assign attr_pos  = pos_q - {2'b00, job_i.dir_len};
  assign is_last   = (pos_q == job_i.total - 5'd1);
  assign next_byte = in_direct ? direct_byte(job_i.kind, job_i.data, pos_q[2:0])
                   : attr_byte(job_i.colour_set, colour_bold(job_i.colour_idx),
                               colour_digit(job_i.colour_idx), job_i.reverse, attr_pos);
  assign job_pop_o = advance && is_last;

  // Position within the head job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 5'd0;
    end else if (advance) begin
      pos_q <= is_last ? 5'd0 : pos_q + 5'd1;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= next_byte;
      out_last_q <= is_last;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign last_o     = out_last_q;

  // The position never runs past the end of the head job.
  `P2A_ASSERT_IMP(a_pos_in_job, clk_i, rst_ni, job_valid_i, pos_q < job_i.total)
  // With no job waiting the position rests at the start.
  `P2A_ASSERT_IMP(a_pos_idle, clk_i, rst_ni, !job_valid_i, pos_q == 5'd0)
  // Finishing a job restarts the position and marks the byte as the last one.
  `P2A_ASSERT_NXT(a_job_end, clk_i, rst_ni, job_pop_o, (pos_q == 5'd0) && last_o && !empty_o)

endmodule

/* rtl/petscii_to_ansi_stream_core.sv */
// Top level of the PETSCII to ANSI stream translator.
// Instantiates p2a_front, p2a_queue and p2a_back; uses p2a_pkg.
//
// Each item is one PETSCII byte and yields zero to seventeen terminal bytes,
// the final one flagged by last_o. While full is low, the front classifies one
// item per cycle and updates the cursor, colour and reverse state at once;
// items that produce bytes enter a four-entry job queue, and the back emits one
// byte per cycle while pop keeps taking them. Items that yield a single byte
// therefore stream at one per cycle when neither side stalls; full rises once
// the queue holds four unfinished jobs. Items that yield no bytes take no queue
// slot. The columns register (reset 40) is written through cfg_we_i and
// cfg_wdata_i.
module petscii_to_ansi_stream_core
  import p2a_pkg::*;
#(
  parameter int CURSOR_BITS = CURSOR_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic accept;
  logic job_valid, head_valid, head_pop;
  job_t job, head;

  assign accept = push && !full;

  // Classification and terminal state.
  p2a_front #(
    .CURSOR_BITS(CURSOR_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .job_valid_o(job_valid),
    .job_o      (job)
  );

  // Job queue.
  p2a_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (job_valid),
    .push_job_i(job),
    .pop_i     (head_pop),
    .full_o    (full),
    .valid_o   (head_valid),
    .head_o    (head)
  );

  // Byte expansion.
  p2a_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(head_valid),
    .job_i      (head),
    .job_pop_o  (head_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the PETSCII to ANSI stream translator.
// Holds its own cursor, colour and reverse tracker to predict the terminal bytes.
// Depends on p2a_pkg and petscii_to_ansi_stream_core only.
`timescale 1ns / 100ps

module tb_top;
  import p2a_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 8;

  // One expected byte of the terminal stream.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } term_byte_t;

  // PETSCII colour codes in colour order, with foreground digit and brightness.
  localparam logic [7:0] COLOUR_CODES [16] = '{
    8'h90, 8'h05, 8'h1C, 8'h9F, 8'h9C, 8'h1E, 8'h1F, 8'h9E,
    8'h81, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B
  };
  localparam logic [7:0] FG_DIGIT [16] = '{
    8'h30, 8'h37, 8'h31, 8'h36, 8'h35, 8'h32, 8'h34, 8'h33,
    8'h31, 8'h33, 8'h31, 8'h30, 8'h37, 8'h32, 8'h34, 8'h37
  };
  localparam logic FG_BRIGHT [16] = '{
    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1
  };
  localparam logic [7:0] CONTROL_CODES [12] = '{
    PC_CR, PC_SHIFT_CR, PC_REV_ON, PC_REV_OFF, PC_HOME, PC_CLEAR,
    PC_DOWN, PC_UP, PC_RIGHT, PC_LEFT, PC_DELETE, PC_BELL
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       push;
  logic       full;
  logic [7:0] in_byte_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte_o;
  logic       last_o;

  // Predicted translator state.
  logic [7:0] columns_q;
  logic [7:0] col_q;
  logic [7:0] line_q;
  logic       rev_q;
  logic       colour_set_q;
  logic [3:0] colour_idx_q;

  term_byte_t expected_term_q [$];
  logic [7:0] pending_petscii_q [$];

  int  items_queued;
  int  items_accepted;
  int  bytes_checked;
  int  mismatches;
  int  widths_written;
  int  cycles;
  int  tx_gap;
  int  rx_gap;
  logic tx_idle_en;
  logic rx_idle_en;
  logic hold_armed;
  logic rx_hold;

  petscii_to_ansi_stream_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_byte_i  (in_byte_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Cursor counters stop at their all-ones value.
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // Works out the terminal bytes of one PETSCII item and updates the tracker.
  function automatic void translate_petscii(input logic [7:0] b);
    logic [7:0] seq [$];
    logic       old_set;
    logic       old_rev;
    logic [3:0] old_idx;
    int         c;
    old_set = colour_set_q;
    old_rev = rev_q;
    old_idx = colour_idx_q;
    if (!(b <= 8'h1F || (b >= 8'h80 && b <= 8'h9F))) begin
      // Printable byte, with a line wrap once the width is reached.
      seq.push_back(b);
      col_q = sat_inc(col_q);
      if (col_q >= columns_q) begin
        col_q  = 8'd0;
        line_q = sat_inc(line_q);
        seq.push_back(T_CR);
        seq.push_back(T_LF);
      end
    end else begin
      case (b)
        PC_CR, PC_SHIFT_CR: begin
          if (b == PC_CR) rev_q = 1'b0;
          col_q  = 8'd0;
          line_q = sat_inc(line_q);
          seq.push_back(T_CR);
          seq.push_back(T_LF);
        end
        PC_REV_ON:  rev_q = 1'b1;
        PC_REV_OFF: rev_q = 1'b0;
        PC_HOME: begin
          col_q  = 8'd0;
          line_q = 8'd0;
          seq = '{T_ESC, T_BRACK, T_UPH};
        end
        PC_CLEAR: begin
          col_q  = 8'd0;
          line_q = 8'd0;
          seq = '{T_ESC, T_BRACK, T_TWO, T_UPJ, T_ESC, T_BRACK, T_UPH};
        end
        PC_DOWN: begin
          line_q = sat_inc(line_q);
          seq = '{T_ESC, T_BRACK, T_UPB};
        end
        PC_UP: begin
          if (line_q != 8'd0) line_q = line_q - 8'd1;
          seq = '{T_ESC, T_BRACK, T_UPA};
        end
        PC_RIGHT: begin
          col_q = sat_inc(col_q);
          seq = '{T_ESC, T_BRACK, T_UPC};
        end
        PC_LEFT: begin
          if (col_q != 8'd0) col_q = col_q - 8'd1;
          seq = '{T_ESC, T_BRACK, T_UPD};
        end
        PC_DELETE: seq = '{T_BS, T_SPACE, T_BS};
        PC_BELL:   seq.push_back(T_BEL);
        default: begin
          // Colour selection; any other control byte does nothing.
          for (c = 0; c < 16; c++) begin
            if (COLOUR_CODES[c] == b) break;
          end
          if (c < 16) begin
            colour_set_q = 1'b1;
            colour_idx_q = c[3:0];
          end
        end
      endcase
      // Attribute string is rebuilt only when something actually changed.
      if (colour_set_q != old_set || rev_q != old_rev ||
          (colour_set_q && colour_idx_q != old_idx)) begin
        seq.push_back(T_ESC); seq.push_back(T_BRACK);
        seq.push_back(T_ZERO); seq.push_back(T_LOWM);
        if (colour_set_q) begin
          if (FG_BRIGHT[colour_idx_q]) begin
            seq.push_back(T_ESC); seq.push_back(T_BRACK);
            seq.push_back(T_ONE); seq.push_back(T_LOWM);
          end
          seq.push_back(T_ESC); seq.push_back(T_BRACK); seq.push_back(T_THREE);
          seq.push_back(FG_DIGIT[colour_idx_q]); seq.push_back(T_LOWM);
        end
        if (rev_q) begin
          seq.push_back(T_ESC); seq.push_back(T_BRACK);
          seq.push_back(T_SEVEN); seq.push_back(T_LOWM);
        end
      end
    end
    for (int i = 0; i < seq.size(); i++) begin
      expected_term_q.push_back('{data: seq[i], last: (i == seq.size() - 1)});
    end
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 24);
  endfunction

  // Random item, biased towards printable text and meaningful control bytes.
  function automatic logic [7:0] random_petscii();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      if ($urandom_range(0, 1) != 0) return 8'($urandom_range(8'h20, 8'h7F));
      return 8'($urandom_range(8'hA0, 8'hFF));
    end
    if (r < 65) return COLOUR_CODES[$urandom_range(0, 15)];
    if (r < 88) return CONTROL_CODES[$urandom_range(0, 11)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void report_mismatch(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
    if (mismatches < 10) begin
      $display("mismatch at byte %0d: %s expected %02h, got %02h",
               bytes_checked, what, want, got);
    end
    mismatches++;
  endfunction

  // Sender: presents queued items, holding each until it is taken.
  always @(posedge clk_i) begin
    logic waiting;
    if (!rst_ni) begin
      push         <= 1'b0;
      in_byte_i    <= 8'd0;
      tx_gap       <= 0;
      col_q        = 8'd0;
      line_q       = 8'd0;
      rev_q        = 1'b0;
      colour_set_q = 1'b0;
      colour_idx_q = 4'd0;
    end else begin
      waiting = push && full;
      if (push && !full) begin
        translate_petscii(in_byte_i);
        items_accepted++;
      end
      if (!waiting) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          push   <= 1'b0;
        end else if (pending_petscii_q.size() != 0) begin
          in_byte_i <= pending_petscii_q.pop_front();
          push      <= 1'b1;
          if (tx_idle_en) tx_gap <= pick_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: takes terminal bytes and checks them against the prediction.
  always @(posedge clk_i) begin
    term_byte_t want;
    if (!rst_ni) begin
      pop    <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_term_q.size() == 0) begin
          report_mismatch("unexpected byte", 8'h00, out_byte_o);
        end else begin
          want = expected_term_q.pop_front();
          if (out_byte_o !== want.data) report_mismatch("out_byte", want.data, out_byte_o);
          if (last_o !== want.last) begin
            report_mismatch("last", {7'd0, want.last}, {7'd0, last_o});
          end
        end
        bytes_checked++;
      end
      if (rx_hold) begin
        pop <= 1'b0;
      end else if (rx_gap != 0) begin
        pop    <= 1'b0;
        rx_gap <= rx_gap - 1;
      end else begin
        pop <= 1'b1;
        if (pop && !empty && rx_idle_en) rx_gap <= pick_gap();
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering items.
  initial begin
    rx_hold = 1'b0;
    wait (hold_armed);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout with %0d items queued, %0d taken", items_queued, items_accepted);
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_item(input logic [7:0] b);
    pending_petscii_q.push_back(b);
    items_queued++;
  endtask

  // Waits until every item is taken and every byte has arrived, then a little more.
  task automatic drain();
    while (items_accepted != items_queued || expected_term_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the line width while the block is idle.
  task automatic set_columns(input logic [7:0] w);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    columns_q = w;
    widths_written++;
  endtask

  task automatic random_chunk(input int n);
    repeat (n) queue_item(random_petscii());
    drain();
  endtask

  // Stimulus.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 8'd0;
    columns_q = COLUMNS_RESET;
    items_queued = 0;
    widths_written = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_armed = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items at the reset width: field extremes, every control, and
    // the cases where attributes do not change or nothing is emitted.
    queue_item(8'h00); queue_item(8'h20); queue_item(8'h7F); queue_item(8'hA0);
    queue_item(8'hFF); queue_item(8'h0E); queue_item(8'h8E); queue_item(8'h80);
    queue_item(COLOUR_CODES[3]); queue_item(COLOUR_CODES[3]);
    queue_item(PC_REV_ON); queue_item(PC_REV_ON); queue_item(PC_CR);
    queue_item(PC_REV_ON); queue_item(PC_SHIFT_CR); queue_item(PC_REV_OFF);
    queue_item(COLOUR_CODES[0]); queue_item(COLOUR_CODES[1]);
    queue_item(PC_DOWN); queue_item(PC_UP); queue_item(PC_UP);
    queue_item(PC_LEFT); queue_item(PC_RIGHT); queue_item(PC_HOME);
    queue_item(PC_CLEAR); queue_item(PC_DELETE); queue_item(PC_BELL);
    drain();

    // Narrowest non-zero width: every printable byte wraps.
    set_columns(8'd1);
    random_chunk(25);

    // Widest width, cursor moves back to back with no idling on either side.
    set_columns(8'd255);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (12) queue_item(PC_RIGHT);
    queue_item(8'h41);
    repeat (6) queue_item(PC_DOWN);
    queue_item(PC_UP);
    queue_item(PC_LEFT);
    drain();

    // Zero width also wraps on every printable byte.
    set_columns(8'd0);
    repeat (6) queue_item(8'($urandom_range(8'h20, 8'h7F)));
    queue_item(PC_CR);
    drain();

    // Random items with the receiver held off long enough to fill the block.
    set_columns(8'd3);
    tx_idle_en = 1'b1;
    hold_armed = 1'b1;
    random_chunk(40);

    // A stretch without any idling.
    set_columns(8'd8);
    tx_idle_en = 1'b0;
    random_chunk(20);

    // Idling on both sides again, at an arbitrary width.
    set_columns(8'($urandom_range(1, 255)));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    random_chunk(20);

    $display("%0d items in, %0d terminal bytes checked, %0d line widths written",
             items_accepted, bytes_checked, widths_written);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
